### design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character codes and the alphabet lookup for the base64
// stream decoder with CR LF framing.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    // framing codes
    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // default result queue depth
    localparam int RESULT_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_QUAD  = 3'd1,
        PH_AFTER = 3'd2,
        PH_CR    = 3'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] quad_pos;
        logic [5:0] pend;
        t_phase     phase;
        logic       pad_seen;
        logic       quad_done;
        logic       err;
    } t_state;

    localparam t_state STATE_RESET = '{
        quad_pos:  2'd0,
        pend:      6'd0,
        phase:     PH_START,
        pad_seen:  1'b0,
        quad_done: 1'b0,
        err:       1'b0
    };

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
        logic       bad;
    } t_result;

    // results of one decode step
    typedef struct packed {
        logic       byte_vld;
        logic [7:0] out_byte;
        logic       end_vld;
        logic       bad;
    } t_step_out;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // alphabet lookup
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.val = 6'd62;
        end else if (c == 8'h2F) begin
            r.val = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/b64d_step.sv
// ----------------------------------------------------------------------------
// b64d_step
// Combinational decode of one character: framing and padding checks, sextet
// packing into bytes and the end-of-text verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_step (
    input  var b64d_pkg::t_state    i_state,
    input  wire logic [7:0]         i_char,
    input  wire logic               i_last,
    output b64d_pkg::t_state        o_next,
    output b64d_pkg::t_step_out     o_res
);

    b64d_pkg::t_state  s;
    b64d_pkg::t_sextet sx;
    logic              do_quad;
    logic              made;
    logic [7:0]        byte_val;
    logic              bad;

    always_comb begin
        s        = i_state;
        sx       = b64d_pkg::sextet_of(i_char);
        do_quad  = 1'b0;
        made     = 1'b0;
        byte_val = 8'd0;
        bad      = 1'b0;

        // framing between quads
        if (!i_state.err) begin
            unique case (i_state.phase)
                b64d_pkg::PH_CR: begin
                    if (i_char == b64d_pkg::CHAR_LF) begin
                        s.phase = b64d_pkg::PH_START;
                    end else begin
                        s.err = 1'b1;
                    end
                end
                b64d_pkg::PH_AFTER: begin
                    if (i_char == b64d_pkg::CHAR_CR) begin
                        s.phase = b64d_pkg::PH_CR;
                    end else if (i_state.pad_seen) begin
                        s.err = 1'b1;
                    end else begin
                        do_quad = 1'b1;
                    end
                end
                b64d_pkg::PH_START: begin
                    if (i_state.pad_seen) begin
                        s.err = 1'b1;
                    end else begin
                        do_quad = 1'b1;
                    end
                end
                b64d_pkg::PH_QUAD: begin
                    do_quad = 1'b1;
                end
                default: begin
                    s.err = 1'b1;
                end
            endcase
        end

        // character within a quad
        if (do_quad) begin
            unique case (i_state.quad_pos)
                2'd0: begin
                    if (!sx.ok) begin
                        s.err = 1'b1;
                    end else begin
                        s.pend     = sx.val;
                        s.quad_pos = 2'd1;
                        s.phase    = b64d_pkg::PH_QUAD;
                    end
                end
                2'd1: begin
                    if (!sx.ok) begin
                        s.err = 1'b1;
                    end else begin
                        byte_val   = {i_state.pend, sx.val[5:4]};
                        s.pend     = {2'b00, sx.val[3:0]};
                        s.quad_pos = 2'd2;
                        made       = 1'b1;
                    end
                end
                2'd2: begin
                    if (i_char == b64d_pkg::CHAR_PAD) begin
                        s.pad_seen = 1'b1;
                        s.quad_pos = 2'd3;
                    end else if (!sx.ok) begin
                        s.err = 1'b1;
                    end else begin
                        byte_val   = {i_state.pend[3:0], sx.val[5:2]};
                        s.pend     = {4'b0000, sx.val[1:0]};
                        s.quad_pos = 2'd3;
                        made       = 1'b1;
                    end
                end
                default: begin
                    if (i_char != b64d_pkg::CHAR_PAD && (i_state.pad_seen || !sx.ok)) begin
                        s.err = 1'b1;
                    end else begin
                        if (i_char == b64d_pkg::CHAR_PAD) begin
                            s.pad_seen = 1'b1;
                        end else begin
                            byte_val = {i_state.pend[1:0], sx.val};
                            made     = 1'b1;
                        end
                        s.quad_pos  = 2'd0;
                        s.pend      = 6'd0;
                        s.phase     = b64d_pkg::PH_AFTER;
                        s.quad_done = 1'b1;
                    end
                end
            endcase
        end

        // end-of-text verdict, then back to the reset state
        bad = s.err || !s.quad_done ||
              !(s.phase == b64d_pkg::PH_AFTER || s.phase == b64d_pkg::PH_START);

        o_res.byte_vld = made && !s.err;
        o_res.out_byte = byte_val;
        o_res.end_vld  = i_last;
        o_res.bad      = bad;
        o_next         = i_last ? b64d_pkg::STATE_RESET : s;
    end

endmodule

`default_nettype wire

### design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Small result queue: takes up to two items per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue #(
    parameter int DEPTH = b64d_pkg::RESULT_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_push_cnt,
    input  var b64d_pkg::t_result   i_push_a,
    input  var b64d_pkg::t_result   i_push_b,
    input  wire logic               i_pop,
    output b64d_pkg::t_result       o_head,
    output logic                    o_not_empty,
    output logic                    o_room2
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic [PW-1:0]     n_wr;
    logic [PW-1:0]     n_rd;
    logic [CW-1:0]     n_cnt;
    logic [PW-1:0]     wr_plus1;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    // pointer and fill count update
    always_comb begin
        wr_plus1 = wrap_inc(r_wr);
        n_wr     = r_wr;
        if (i_push_cnt == 2'd1) begin
            n_wr = wr_plus1;
        end else if (i_push_cnt == 2'd2) begin
            n_wr = wrap_inc(wr_plus1);
        end
        n_rd  = i_pop ? wrap_inc(r_rd) : r_rd;
        n_cnt = CW'(r_cnt + CW'(i_push_cnt) - CW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_plus1] <= i_push_b;
        end
    end

    assign o_head      = r_mem[r_rd];
    assign o_not_empty = (r_cnt != '0);
    assign o_room2     = (r_cnt <= CW'(DEPTH - 2));

endmodule

`default_nettype wire

### design/base64_stream_decoder_crlf_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_crlf_unit
// Streaming base64 decoder with optional CR LF after each quad.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one text character per item,
//   with i_last on the final character. Output channel (o_valid / i_ready)
//   carries decoded bytes and, after the final character, one end item
//   (o_is_end = 1) whose o_bad_input flags malformed text.
//   One character is taken per cycle while the queue has room for two items.
//   It is held in an input register, decoded combinationally and its results
//   (none, one or two items) are written into a small result queue. A result
//   passes through the input register and the result queue before it can be
//   taken. Throughput is one character per cycle while that room exists; the
//   single output port moves one result per cycle, so a character that yields
//   both a byte and the end item needs two transfers on the output side.
//   The input stalls only while the result queue has fewer than two free
//   entries, so a stalled receiver fills the queue and then back-pressures.
//   Reset empties the queue and the input register and returns the decoder
//   to the start of a quad; the end item also returns it there.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_crlf_unit #(
    parameter int DEPTH = b64d_pkg::RESULT_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_is_end,
    output logic            o_bad_input
);

    logic                 r_in_vld;
    logic [7:0]           r_char;
    logic                 r_last;
    b64d_pkg::t_state     r_state;
    b64d_pkg::t_state     n_state;
    b64d_pkg::t_step_out  step_res;
    b64d_pkg::t_result    push_a;
    b64d_pkg::t_result    push_b;
    b64d_pkg::t_result    head;
    logic [1:0]           push_cnt;
    logic                 room2;
    logic                 advance;

    // input register moves on when the queue has room for two items
    assign advance = r_in_vld && room2;
    assign o_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_in_char;
            r_last <= i_last;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b64d_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    b64d_step u_step (
        .i_state (r_state),
        .i_char  (r_char),
        .i_last  (r_last),
        .o_next  (n_state),
        .o_res   (step_res)
    );

    // pack the step results into queue items, byte first
    always_comb begin
        push_b.out_byte = 8'd0;
        push_b.is_end   = 1'b1;
        push_b.bad      = step_res.bad;
        if (step_res.byte_vld) begin
            push_a.out_byte = step_res.out_byte;
            push_a.is_end   = 1'b0;
            push_a.bad      = 1'b0;
        end else begin
            push_a = push_b;
        end
        push_cnt = advance ? (2'(step_res.byte_vld) + 2'(step_res.end_vld)) : 2'd0;
    end

    b64d_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push_a    (push_a),
        .i_push_b    (push_b),
        .i_pop       (o_valid && i_ready),
        .o_head      (head),
        .o_not_empty (o_valid),
        .o_room2     (room2)
    );

    assign o_out_byte  = head.out_byte;
    assign o_is_end    = head.is_end;
    assign o_bad_input = head.bad;

    // checks
    a_byte_not_bad : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_end |-> !o_bad_input)
        else $error("data byte item carries bad flag");

    a_end_zero_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_end |-> o_out_byte == 8'd0)
        else $error("end item carries a non-zero byte");

    a_last_resets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |=> r_state == b64d_pkg::STATE_RESET)
        else $error("decoder state not cleared after last character");

    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with an empty result queue");

endmodule

`default_nettype wire
